>>> hdl/cte_pkg.sv
// Shared types and constants of the garbage-collector card table engine.
package cte_pkg;

   localparam int ADDR_W         = 48;
   localparam int CNT_W          = 7;
   localparam int CSR_IDX_W      = 1;
   localparam int DEF_NUM_CARDS  = 64;
   localparam int DEF_CARD_BITS  = 9;
   localparam int DEF_ADDR_BITS  = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CARDS = 1'b1;

   localparam logic CARD_CLEAN = 1'b0;
   localparam logic CARD_DIRTY = 1'b1;

   typedef enum logic [2:0] {
      KIND_MARK_DIRTY = 3'd0,
      KIND_MARK_CLEAN = 3'd1,
      KIND_QUERY      = 3'd2,
      KIND_CLEAR_ALL  = 3'd3,
      KIND_SCAN_ALL   = 3'd4,
      KIND_SCAN_RANGE = 3'd5,
      KIND_COUNT      = 3'd6
   } kind_type;

   // Classified request handed from the front end to the back end. For marks and
   // queries lo holds the card index; for scans and counts lo..hi is the card walk.
   typedef struct packed {
      kind_type           kind;
      logic               ok;
      logic [CNT_W-1:0]   lo;
      logic [CNT_W-1:0]   hi;
   } cte_cmd_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  card_start;
      logic [ADDR_W-1:0]  card_stop;
      logic               found;
      logic [CNT_W-1:0]   dirty_total;
      logic               is_last;
   } cte_rsp_type;

endpackage

>>> hdl/cte_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cte_ram
   import cte_pkg::*;
#(
   parameter int WIDTH = 1,
   parameter int DEPTH = DEF_NUM_CARDS
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/cte_fifo.sv
// Small register queue used between the front and back ends and on the result side.
module cte_fifo
   import cte_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             wr_full,
   input  logic             rd_pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             rd_empty
);

   localparam int PTRW = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign rd_empty = (count_ff == '0);
   assign wr_full  = (count_ff == CNTW'(DEPTH));
   assign do_push  = wr_push && !wr_full;
   assign do_pop   = rd_pop && !rd_empty;
   assign rd_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> hdl/cte_front.sv
// Front end: takes requests into a stage register and turns addresses into card indices.
module cte_front
   import cte_pkg::*;
#(
   parameter int CARD_BITS  = DEF_CARD_BITS,
   parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [2:0]        req_kind,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [ADDR_W-1:0] req_range_end,
   input  logic [ADDR_W-1:0] heap_base,
   input  logic [CNT_W-1:0]  cards_used,
   output logic              cmd_push,
   output cte_cmd_type       cmd_data,
   input  logic              cmd_full
);

   localparam int AW = ADDR_BITS < ADDR_W ? ADDR_BITS : ADDR_W;

   typedef struct packed {
      logic             ok;
      logic [CNT_W-1:0] card;
   } look_type;

   logic              stg_valid_ff, stg_valid_in;
   logic [2:0]        stg_kind_ff;
   logic [ADDR_W-1:0] stg_addr_ff;
   logic [ADDR_W-1:0] stg_end_ff;
   logic              accept;
   look_type          start_look, end_look;

   // Card lookup: valid when at or above the base and inside the cards in use.
   function automatic look_type card_look(input logic [AW-1:0] a, input logic [AW-1:0] base,
                                          input logic [CNT_W-1:0] used);
      logic [AW-1:0] card;
      look_type      r;
      card   = (a - base) >> CARD_BITS;
      r.ok   = (a >= base) && (card < AW'(used));
      r.card = card[CNT_W-1:0];
      return r;
   endfunction

   assign cmd_push     = stg_valid_ff && !cmd_full;
   assign full         = stg_valid_ff && cmd_full;
   assign accept       = push && !full;
   assign stg_valid_in = accept ? 1'b1 : (cmd_push ? 1'b0 : stg_valid_ff);

   assign start_look = card_look(stg_addr_ff[AW-1:0], heap_base[AW-1:0], cards_used);
   assign end_look   = card_look(stg_end_ff[AW-1:0], heap_base[AW-1:0], cards_used);

   always_comb begin
      cmd_data      = '0;
      cmd_data.kind = kind_type'(stg_kind_ff);
      cmd_data.ok   = start_look.ok;
      case (kind_type'(stg_kind_ff))
         KIND_SCAN_ALL, KIND_COUNT: begin
            cmd_data.lo = '0;
            cmd_data.hi = cards_used;
         end
         KIND_SCAN_RANGE: begin
            // A start outside the table leaves an empty walk; an end outside runs to the end.
            cmd_data.lo = start_look.ok ? start_look.card : cards_used;
            cmd_data.hi = end_look.ok ? end_look.card : cards_used;
         end
         default: begin
            cmd_data.lo = start_look.card;
            cmd_data.hi = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_kind_ff <= req_kind;
         stg_addr_ff <= req_address;
         stg_end_ff  <= req_range_end;
      end
   end

endmodule

>>> hdl/cte_back.sv
// Back end: holds the card table and carries out marks, queries, clears, scans and counts.
module cte_back
   import cte_pkg::*;
#(
   parameter int NUM_CARDS  = DEF_NUM_CARDS,
   parameter int CARD_BITS  = DEF_CARD_BITS,
   parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [ADDR_W-1:0] heap_base,
   input  cte_cmd_type       cmd_data,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   output logic              rsp_push,
   output cte_rsp_type       rsp_data,
   input  logic              rsp_full
);

   localparam int AW   = ADDR_BITS < ADDR_W ? ADDR_BITS : ADDR_W;
   localparam int IDXW = NUM_CARDS > 1 ? $clog2(NUM_CARDS) : 1;
   localparam logic [AW-1:0] CARD_BYTES = AW'(1) << CARD_BITS;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_QUERY = 4'b0010,
      S_READ  = 4'b0100,
      S_CHECK = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [NUM_CARDS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             is_count_ff, is_count_in;
   logic             held_ff, held_in;
   logic [AW-1:0]    held_start_ff, held_start_in;
   logic             qok_ff, qok_in;
   logic             vq_ff;
   logic             ram_we, ram_wd, ram_re, ram_rd;
   logic [IDXW-1:0]  ram_wa, ram_ra;
   logic             clear_go;
   logic             card_dirty;

   cte_ram #(.WIDTH(1), .DEPTH(NUM_CARDS)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign card_dirty = ram_rd && vq_ff;

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      ptr_in        = ptr_ff;
      hi_in         = hi_ff;
      cnt_in        = cnt_ff;
      is_count_in   = is_count_ff;
      held_in       = held_ff;
      held_start_in = held_start_ff;
      qok_in        = qok_ff;
      cmd_pop       = 1'b0;
      rsp_push      = 1'b0;
      rsp_data      = '0;
      ram_we        = 1'b0;
      ram_wd        = CARD_CLEAN;
      ram_wa        = cmd_data.lo[IDXW-1:0];
      ram_re        = 1'b0;
      ram_ra        = ptr_ff[IDXW-1:0];
      clear_go      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               case (cmd_data.kind)
                  KIND_MARK_DIRTY, KIND_MARK_CLEAN: begin
                     if (!rsp_full) begin
                        cmd_pop          = 1'b1;
                        ram_we           = cmd_data.ok;
                        ram_wd           = (cmd_data.kind == KIND_MARK_DIRTY) ?
                                           CARD_DIRTY : CARD_CLEAN;
                        if (cmd_data.ok) begin
                           valid_in[cmd_data.lo[IDXW-1:0]] = 1'b1;
                        end
                        rsp_push         = 1'b1;
                        rsp_data.is_last = 1'b1;
                     end
                  end
                  KIND_QUERY: begin
                     cmd_pop  = 1'b1;
                     ram_re   = 1'b1;
                     ram_ra   = cmd_data.lo[IDXW-1:0];
                     qok_in   = cmd_data.ok;
                     state_in = S_QUERY;
                  end
                  KIND_CLEAR_ALL: begin
                     if (!rsp_full) begin
                        cmd_pop          = 1'b1;
                        clear_go         = 1'b1;
                        valid_in         = '0;
                        rsp_push         = 1'b1;
                        rsp_data.is_last = 1'b1;
                     end
                  end
                  KIND_SCAN_ALL, KIND_SCAN_RANGE, KIND_COUNT: begin
                     cmd_pop     = 1'b1;
                     ptr_in      = cmd_data.lo;
                     hi_in       = cmd_data.hi;
                     cnt_in      = '0;
                     held_in     = 1'b0;
                     is_count_in = (cmd_data.kind == KIND_COUNT);
                     state_in    = S_READ;
                  end
                  default: begin
                     if (!rsp_full) begin
                        cmd_pop          = 1'b1;
                        rsp_push         = 1'b1;
                        rsp_data.is_last = 1'b1;
                     end
                  end
               endcase
            end
         end
         S_QUERY: begin
            if (!rsp_full) begin
               rsp_push         = 1'b1;
               rsp_data.found   = qok_ff && card_dirty;
               rsp_data.is_last = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_READ: begin
            if (ptr_ff < hi_ff) begin
               ram_re   = 1'b1;
               state_in = S_CHECK;
            end else if (!rsp_full) begin
               rsp_push         = 1'b1;
               rsp_data.is_last = 1'b1;
               if (is_count_ff) begin
                  rsp_data.dirty_total = cnt_ff;
               end else if (held_ff) begin
                  rsp_data.card_start = ADDR_W'(held_start_ff);
                  rsp_data.card_stop  = ADDR_W'(held_start_ff + CARD_BYTES);
                  rsp_data.found      = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_CHECK: begin
            if (is_count_ff) begin
               cnt_in   = cnt_ff + CNT_W'(card_dirty);
               ptr_in   = ptr_ff + 1'b1;
               state_in = S_READ;
            end else if (!(card_dirty && held_ff && rsp_full)) begin
               if (card_dirty) begin
                  // A newer dirty card means the held one is not the last.
                  if (held_ff) begin
                     rsp_push            = 1'b1;
                     rsp_data.card_start = ADDR_W'(held_start_ff);
                     rsp_data.card_stop  = ADDR_W'(held_start_ff + CARD_BYTES);
                     rsp_data.found      = 1'b1;
                  end
                  held_in       = 1'b1;
                  held_start_in = heap_base[AW-1:0] + (AW'(ptr_ff) << CARD_BITS);
               end
               ptr_in   = ptr_ff + 1'b1;
               state_in = S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         held_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      hi_ff         <= hi_in;
      cnt_ff        <= cnt_in;
      is_count_ff   <= is_count_in;
      held_start_ff <= held_start_in;
      qok_ff        <= qok_in;
      if (ram_re) begin
         vq_ff <= valid_ff[ram_ra];
      end
   end

`ifndef ASSERT_OFF
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full queue");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (ptr_ff < hi_ff))
      else $error("card walk checked a card beyond its end");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      clear_go |=> (valid_ff == '0))
      else $error("clear all left a card marked");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (cnt_ff <= CNT_W'(NUM_CARDS)))
      else $error("dirty count exceeds the table size");
`endif

endmodule

>>> hdl/gc_card_table_engine_top.sv
// Top level of the garbage-collector card table engine: registers, queues and both ends.
//
// The engine keeps one dirty bit per card of 2**CARD_BITS bytes from heap_base and
// takes requests through a queue-like port (push/full) and hands back results through
// another (empty/pop). A request is first held in a stage register, where its addresses
// are turned into card indices, and then passes through a two-entry command queue to
// the back end, which owns the card table RAM. Marks, clear-all and undefined kinds
// are finished by the back end in its idle state, so a stream of write-barrier marks
// is taken at one request per cycle once the pipeline is full and while the result
// queue has room; a query also passes through S_QUERY because the table RAM has a
// registered read. Scans and counts walk the card range through the single RAM read
// port, reading each card in S_READ and checking it in S_CHECK, and send the final
// result from S_READ; the walk stalls whenever a result waits for room in the result
// queue. The table is empty straight after reset, with no clearing pass. The user must
// write heap_base and num_cards through the csr port only while no request is in
// flight; the block itself does not enforce it. num_cards above NUM_CARDS is treated
// as NUM_CARDS.
module gc_card_table_engine_top
   import cte_pkg::*;
#(
   parameter int NUM_CARDS  = DEF_NUM_CARDS,
   parameter int CARD_BITS  = DEF_CARD_BITS,
   parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   // Request side
   input  logic                 push,
   output logic                 full,
   input  logic [2:0]           req_kind,
   input  logic [ADDR_W-1:0]    req_address,
   input  logic [ADDR_W-1:0]    req_range_end,
   // Result side
   output logic                 empty,
   input  logic                 pop,
   output logic [ADDR_W-1:0]    rsp_card_start,
   output logic [ADDR_W-1:0]    rsp_card_stop,
   output logic                 rsp_found,
   output logic [CNT_W-1:0]     rsp_dirty_total,
   output logic                 rsp_is_last,
   // Configuration writes
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata
);

   logic [ADDR_W-1:0] heap_base_ff;
   logic [CNT_W-1:0]  num_cards_ff;
   logic [CNT_W-1:0]  cards_used;

   logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
   cte_cmd_type       cmd_wr, cmd_rd;
   logic              rsp_push, rsp_full;
   cte_rsp_type       rsp_wr, rsp_rd;

   // Configuration registers. Both reset to zero, so the table starts with no cards in use.
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= '0;
         num_cards_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HEAP_BASE: heap_base_ff <= csr_wdata;
            CSR_NUM_CARDS: num_cards_ff <= csr_wdata[CNT_W-1:0];
            default:       heap_base_ff <= heap_base_ff;
         endcase
      end
   end

   // The number of cards in use never exceeds the size of the table.
   assign cards_used = (num_cards_ff > CNT_W'(NUM_CARDS)) ? CNT_W'(NUM_CARDS) : num_cards_ff;

   cte_front #(
      .CARD_BITS  (CARD_BITS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_kind      (req_kind),
      .req_address   (req_address),
      .req_range_end (req_range_end),
      .heap_base     (heap_base_ff),
      .cards_used    (cards_used),
      .cmd_push      (cmd_push),
      .cmd_data      (cmd_wr),
      .cmd_full      (cmd_full)
   );

   // The command queue lets the front end keep taking requests while a scan is running.
   cte_fifo #(
      .WIDTH ($bits(cte_cmd_type)),
      .DEPTH (2)
   ) u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (cmd_push),
      .wr_data  (cmd_wr),
      .wr_full  (cmd_full),
      .rd_pop   (cmd_pop),
      .rd_data  (cmd_rd),
      .rd_empty (cmd_empty)
   );

   cte_back #(
      .NUM_CARDS  (NUM_CARDS),
      .CARD_BITS  (CARD_BITS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .heap_base (heap_base_ff),
      .cmd_data  (cmd_rd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wr),
      .rsp_full  (rsp_full)
   );

   // The result queue decouples the back end from a slow consumer.
   cte_fifo #(
      .WIDTH ($bits(cte_rsp_type)),
      .DEPTH (2)
   ) u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (rsp_push),
      .wr_data  (rsp_wr),
      .wr_full  (rsp_full),
      .rd_pop   (pop),
      .rd_data  (rsp_rd),
      .rd_empty (empty)
   );

   assign rsp_card_start  = rsp_rd.card_start;
   assign rsp_card_stop   = rsp_rd.card_stop;
   assign rsp_found       = rsp_rd.found;
   assign rsp_dirty_total = rsp_rd.dirty_total;
   assign rsp_is_last     = rsp_rd.is_last;

endmodule
